/* rtl/hdsc_pkg.sv */
// Package: SHA-256 constants, word types and round functions for the header checker.
`default_nettype none
package hdsc_pkg;

   typedef logic [7:0][31:0]  sha_state_type;   // [0] = a / H0
   typedef logic [15:0][31:0] sha_block_type;   // [0] = first word

   localparam int DIFF_W = 7;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam sha_state_type SHA_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam logic [31:0] PAD_WORD = 32'h80000000;
   localparam logic [31:0] LEN_HDR  = 32'd640;  // 80 bytes
   localparam logic [31:0] LEN_DIG  = 32'd256;  // 32 bytes

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

/* rtl/hdsc_round_cell.sv */
// One SHA-256 round cell: round on the working state, slides the message window.
`default_nettype none
module hdsc_round_cell
   import hdsc_pkg::*;
#(
   parameter int IDX = 0,
   parameter int SW  = 1
) (
   input  wire            clock,
   input  wire            reset,
   input  wire            en,
   input  wire            in_valid,
   input  sha_state_type  in_st,
   input  sha_block_type  in_win,
   input  sha_state_type  in_chain,
   input  wire [SW-1:0]   in_side,
   output logic           out_valid,
   output sha_state_type  out_st,
   output sha_block_type  out_win,
   output sha_state_type  out_chain,
   output logic [SW-1:0]  out_side
);

   logic [31:0]   t1, t2, s0, s1, w_next;
   sha_state_type st_in;
   sha_block_type win_in;
   logic          valid_ff;
   sha_state_type st_ff, chain_ff;
   sha_block_type win_ff;
   logic [SW-1:0] side_ff;

   always_comb begin
      t1 = in_st[7] + (rotr(in_st[4], 6) ^ rotr(in_st[4], 11) ^ rotr(in_st[4], 25))
         + ((in_st[4] & in_st[5]) ^ (~in_st[4] & in_st[6])) + SHA_K[IDX] + in_win[0];
      t2 = (rotr(in_st[0], 2) ^ rotr(in_st[0], 13) ^ rotr(in_st[0], 22))
         + ((in_st[0] & in_st[1]) ^ (in_st[0] & in_st[2]) ^ (in_st[1] & in_st[2]));
      st_in    = {in_st[6:4], in_st[3] + t1, in_st[2:0], t1 + t2};
      s0 = rotr(in_win[1], 7) ^ rotr(in_win[1], 18) ^ (in_win[1] >> 3);
      s1 = rotr(in_win[14], 17) ^ rotr(in_win[14], 19) ^ (in_win[14] >> 10);
      w_next = in_win[0] + s0 + in_win[9] + s1;
      win_in = {w_next, in_win[15:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         st_ff    <= st_in;
         win_ff   <= win_in;
         chain_ff <= in_chain;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;
   assign out_win   = win_ff;
   assign out_chain = chain_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

/* rtl/hdsc_compress.sv */
// SHA-256 compression as a chain of 64 round cells plus a feed-forward stage.
`default_nettype none
module hdsc_compress
   import hdsc_pkg::*;
#(
   parameter int SW = 1
) (
   input  wire            clock,
   input  wire            reset,
   input  wire            en,
   input  wire            in_valid,
   input  sha_state_type  in_chain,
   input  sha_block_type  in_block,
   input  wire [SW-1:0]   in_side,
   output logic           out_valid,
   output sha_state_type  out_hash,
   output logic [SW-1:0]  out_side
);

   logic          v   [65];
   sha_state_type st  [65];
   sha_block_type win [65];
   sha_state_type ch  [65];
   logic [SW-1:0] sd  [65];

   logic          valid_ff;
   sha_state_type hash_ff;
   logic [SW-1:0] side_ff;

   assign v[0]   = in_valid;
   assign st[0]  = in_chain;
   assign win[0] = in_block;
   assign ch[0]  = in_chain;
   assign sd[0]  = in_side;

   for (genvar i = 0; i < 64; i++) begin : g_cell
      hdsc_round_cell #(.IDX(i), .SW(SW)) u_cell (
         .clock, .reset, .en,
         .in_valid (v[i]),   .in_st (st[i]),   .in_win (win[i]),
         .in_chain (ch[i]),  .in_side (sd[i]),
         .out_valid(v[i+1]), .out_st(st[i+1]), .out_win(win[i+1]),
         .out_chain(ch[i+1]), .out_side(sd[i+1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= v[64];
      end
      if (en) begin
         for (int j = 0; j < 8; j++) begin
            hash_ff[j] <= ch[64][j] + st[64][j];
         end
         side_ff <= sd[64];
      end
   end

   assign out_valid = valid_ff;
   assign out_hash  = hash_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

/* rtl/header_double_sha256_check_unit.sv */
// Top level: block header double SHA-256 with leading-zero-digit check.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata  640b header fields
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata  264b digest, count, flag
//  csr     | in  | csr_valid/csr_ready    | csr_data   difficulty_digits
//
// One request per clock while not stalled; three compressions of 64 round
// cells plus a feed-forward register each, a digit-count stage, output register.
// Every stage advances together when the output register is empty or taken.
// Reset (synchronous) clears valid bits and difficulty; data regs not reset.
// req_tready and csr_ready are held low during reset; csr_ready is high otherwise.
`default_nettype none
module header_double_sha256_check_unit
   import hdsc_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // header_version, prev_hash_w0..w3, merkle_w0..w3, header_time,
   // target_bits, nonce_value (low bits first)
   input  wire  [639:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // digest_w0..w3, zero_nibbles[262:256], meets_target[263]
   output logic [263:0] rsp_tdata,
   input  wire          csr_valid,
   output logic         csr_ready,
   // difficulty_digits[6:0], bit 7 zero
   input  wire  [7:0]   csr_data
);

   logic              adv;
   logic [DIFF_W-1:0] diff_ff;

   sha_block_type     blk1, blk2, blk3;
   logic [127:0]      tail_words;
   logic              c1_v, c2_v, c3_v;
   sha_state_type     c1_h, c2_h, c3_h;
   logic [127:0]      c1_side;
   logic [255:0]      dig;

   // digit-count stage
   logic              cnt_v_ff;
   logic [255:0]      cnt_dig_ff;
   logic [3:0]        grp_ff [8];
   logic [3:0]        grp_in [8];

   // output register
   logic              out_v_ff;
   logic [255:0]      out_dig_ff;
   logic [6:0]        out_zn_ff;
   logic              out_meet_ff;
   logic [6:0]        zn_in;

   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv && !reset;
   assign csr_ready  = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff <= '0;
      end else if (csr_valid) begin
         diff_ff <= csr_data[DIFF_W-1:0];
      end
   end

   // header words are byte-swapped 32-bit chunks of the request
   always_comb begin
      for (int j = 0; j < 16; j++) begin
         blk1[j] = bswap(req_tdata[32*j +: 32]);
      end
      for (int j = 0; j < 4; j++) begin
         tail_words[32*j +: 32] = bswap(req_tdata[512 + 32*j +: 32]);
      end
   end

   hdsc_compress #(.SW(128)) u_c1 (
      .clock, .reset, .en(adv),
      .in_valid(req_tvalid && req_tready), .in_chain(SHA_IV), .in_block(blk1),
      .in_side(tail_words),
      .out_valid(c1_v), .out_hash(c1_h), .out_side(c1_side));

   always_comb begin
      blk2 = '0;
      for (int j = 0; j < 4; j++) begin
         blk2[j] = c1_side[32*j +: 32];
      end
      blk2[4]  = PAD_WORD;
      blk2[15] = LEN_HDR;
   end

   hdsc_compress #(.SW(1)) u_c2 (
      .clock, .reset, .en(adv),
      .in_valid(c1_v), .in_chain(c1_h), .in_block(blk2), .in_side(1'b0),
      .out_valid(c2_v), .out_hash(c2_h), .out_side());

   always_comb begin
      blk3 = '0;
      for (int j = 0; j < 8; j++) begin
         blk3[j] = c2_h[j];
      end
      blk3[8]  = PAD_WORD;
      blk3[15] = LEN_DIG;
   end

   hdsc_compress #(.SW(1)) u_c3 (
      .clock, .reset, .en(adv),
      .in_valid(c2_v), .in_chain(SHA_IV), .in_block(blk3), .in_side(1'b0),
      .out_valid(c3_v), .out_hash(c3_h), .out_side());

   // first digest byte least significant
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         dig[32*j +: 32] = bswap(c3_h[j]);
      end
   end

   // leading zero nibbles per 32-bit group, top group first
   always_comb begin
      logic stop;
      for (int g = 0; g < 8; g++) begin
         grp_in[g] = '0;
         stop = 1'b0;
         for (int n = 7; n >= 0; n--) begin
            if (!stop && dig[32*(7-g) + 4*n +: 4] == 4'h0) begin
               grp_in[g] = grp_in[g] + 4'd1;
            end else begin
               stop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_v_ff <= 1'b0;
      end else if (adv) begin
         cnt_v_ff <= c3_v;
      end
      if (adv) begin
         cnt_dig_ff <= dig;
         grp_ff     <= grp_in;
      end
   end

   always_comb begin
      logic open;
      zn_in = '0;
      open  = 1'b1;
      for (int g = 0; g < 8; g++) begin
         if (open) begin
            zn_in = zn_in + {3'b0, grp_ff[g]};
         end
         open = open && (grp_ff[g] == 4'd8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= cnt_v_ff;
      end
      if (adv) begin
         out_dig_ff  <= cnt_dig_ff;
         out_zn_ff   <= zn_in;
         out_meet_ff <= (zn_in >= diff_ff);
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_meet_ff, out_zn_ff, out_dig_ff};

`ifndef NO_ASSERTIONS
   a_zn_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_zn_ff <= 7'd64))
      else $error("zero nibble count above 64");
   a_zero_dig: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_zn_ff == 7'd64) == (out_dig_ff == '0)))
      else $error("count of 64 does not match all-zero digest");
   a_top_nib: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_dig_ff[255:252] != 4'h0) |-> (out_zn_ff == 7'd0))
      else $error("nonzero top digit but count nonzero");
   a_meet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_meet_ff == (out_zn_ff >= diff_ff)))
      else $error("target flag disagrees with count");
`endif

endmodule
`default_nettype wire

/* verif/header_double_sha256_check_unit_tb.sv */
// Testbench for the block header double SHA-256 checker: random and directed headers.
`timescale 1ns / 100ps
`default_nettype none
module header_double_sha256_check_unit_tb;
   import hdsc_pkg::*;

   localparam int LATENCY = 197;

   typedef struct packed {
      logic [31:0] nonce_value;
      logic [31:0] target_bits;
      logic [31:0] header_time;
      logic [3:0][63:0] merkle;
      logic [3:0][63:0] prev_hash;
      logic [31:0] header_version;
   } header_type;

   typedef struct packed {
      logic       meets_target;
      logic [6:0] zero_nibbles;
      logic [255:0] digest;
   } verdict_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [639:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [263:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;

   logic [6:0]   difficulty_model = '0;
   verdict_type  verdict_queue [$];
   int           error_count = 0;
   bit           stall_heavy = 1'b0;

   header_double_sha256_check_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- SHA-256 predictor ----------------
   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one compression; block given as 64 bytes, byte 0 first
   function automatic sha_state_type sha_round_block(sha_state_type st,
                                                     logic [7:0] blk [64]);
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      sha_state_type nxt;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = st[0]; b = st[1]; c = st[2]; d = st[3];
      e = st[4]; f = st[5]; g = st[6]; h = st[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      nxt[0] = st[0] + a; nxt[1] = st[1] + b; nxt[2] = st[2] + c; nxt[3] = st[3] + d;
      nxt[4] = st[4] + e; nxt[5] = st[5] + f; nxt[6] = st[6] + g; nxt[7] = st[7] + h;
      return nxt;
   endfunction

   function automatic verdict_type predict_verdict(header_type hd, logic [6:0] need);
      logic [7:0] msg [128];
      logic [7:0] blk [64];
      logic [7:0] first [32];
      logic [7:0] dig [32];
      logic [639:0] flat;
      sha_state_type st;
      verdict_type v;
      int zeros;
      bit stop;
      // header struct is packed lowest field in low bits, so byte i = flat[8i+:8]
      flat = hd;
      foreach (msg[i]) msg[i] = 8'h00;
      for (int i = 0; i < 80; i++) msg[i] = flat[8*i +: 8];
      msg[80] = 8'h80;
      msg[126] = 8'h02;  // length 640 bits
      msg[127] = 8'h80;
      st = SHA_IV;
      for (int i = 0; i < 64; i++) blk[i] = msg[i];
      st = sha_round_block(st, blk);
      for (int i = 0; i < 64; i++) blk[i] = msg[64 + i];
      st = sha_round_block(st, blk);
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 4; j++) first[4*i+j] = st[i][31-8*j -: 8];
      // second pass over the 32-byte digest
      foreach (blk[i]) blk[i] = 8'h00;
      for (int i = 0; i < 32; i++) blk[i] = first[i];
      blk[32] = 8'h80;
      blk[62] = 8'h01;   // length 256 bits
      st = sha_round_block(SHA_IV, blk);
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 4; j++) dig[4*i+j] = st[i][31-8*j -: 8];
      for (int i = 0; i < 32; i++) v.digest[8*i +: 8] = dig[i];
      zeros = 0;
      stop = 1'b0;
      for (int i = 31; i >= 0 && !stop; i--) begin
         if (dig[i][7:4] == 4'h0) begin
            zeros++;
            if (dig[i][3:0] == 4'h0) zeros++;
            else stop = 1'b1;
         end else begin
            stop = 1'b1;
         end
      end
      v.zero_nibbles = zeros[6:0];
      v.meets_target = (zeros >= need);
      return v;
   endfunction

   // ---------------- reporting / checking ----------------
   task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // stall pattern on the result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_heavy) begin
         rsp_tready <= ($urandom_range(0, 9) == 0);
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected result", got.digest, '0);
         end else begin
            want = verdict_queue.pop_front();
            if (got.digest[63:0] !== want.digest[63:0])
               report_mismatch("digest_w0", got.digest[63:0], want.digest[63:0]);
            if (got.digest[127:64] !== want.digest[127:64])
               report_mismatch("digest_w1", got.digest[127:64], want.digest[127:64]);
            if (got.digest[191:128] !== want.digest[191:128])
               report_mismatch("digest_w2", got.digest[191:128], want.digest[191:128]);
            if (got.digest[255:192] !== want.digest[255:192])
               report_mismatch("digest_w3", got.digest[255:192], want.digest[255:192]);
            if (got.zero_nibbles !== want.zero_nibbles)
               report_mismatch("zero_nibbles", got.zero_nibbles, want.zero_nibbles);
            if (got.meets_target !== want.meets_target)
               report_mismatch("meets_target", got.meets_target, want.meets_target);
         end
      end
   end

   // ---------------- stimulus helpers ----------------
   // send one request; gap first, mostly none, sometimes short, rarely long
   task automatic send_header(header_type hd, bit gaps = 1'b1);
      int gap;
      gap = 0;
      if (gaps) begin
         if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 60);
         else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= hd;
      verdict_queue = {verdict_queue, predict_verdict(hd, difficulty_model)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // register write: only while idle
   task automatic write_difficulty(logic [6:0] digits);
      csr_valid <= 1'b1;
      csr_data  <= {1'b0, digits};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      difficulty_model = digits;
   endtask

   function automatic header_type random_header();
      header_type hd;
      hd.header_version = $urandom;
      for (int k = 0; k < 4; k++) begin
         hd.prev_hash[k] = {$urandom, $urandom};
         hd.merkle[k]    = {$urandom, $urandom};
      end
      hd.header_time = $urandom;
      hd.target_bits = $urandom;
      hd.nonce_value = $urandom;
      return hd;
   endfunction

   // ---------------- tests ----------------
   task automatic test_field_extremes();
      header_type hd;
      send_header('0);
      send_header('1);
      hd = '0; hd.header_version = '1; send_header(hd);
      hd = '0; hd.prev_hash = '1; send_header(hd);
      hd = '0; hd.merkle = '1; send_header(hd);
      hd = '0; hd.header_time = '1; hd.target_bits = '1; send_header(hd);
      hd = '0; hd.nonce_value = '1; send_header(hd);
      hd = '0; hd.header_version = 32'h0000_0001; hd.nonce_value = 32'h8000_0000;
      send_header(hd);
      drain_results();
   endtask

   // difficulty zero always passes, large values never do
   task automatic test_difficulty_sweep();
      logic [6:0] levels [6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
      foreach (levels[i]) begin
         write_difficulty(levels[i]);
         for (int n = 0; n < 3; n++) send_header(random_header());
         drain_results();
      end
   endtask

   // back to back requests under heavy result stall
   task automatic test_backpressure();
      stall_heavy = 1'b1;
      for (int n = 0; n < 40; n++) send_header(random_header(), 1'b0);
      req_tvalid <= 1'b0;
      repeat (300) @(posedge clock);
      stall_heavy = 1'b0;
      drain_results();
   endtask

   task automatic test_random_headers(int count);
      header_type hd, base;
      base = random_header();
      for (int n = 0; n < count; n++) begin
         // most are nonce sweeps over a fixed header, as a miner would issue
         if ($urandom_range(0, 3) != 0) begin
            hd = base;
            hd.nonce_value = base.nonce_value + n;
         end else begin
            hd = random_header();
            base = hd;
         end
         send_header(hd, $urandom_range(0, 4) != 0);
         if (n % 300 == 299) begin
            drain_results();
            write_difficulty(7'($urandom_range(0, 4)));
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_difficulty_sweep();
      test_backpressure();
      write_difficulty(7'd1);
      test_random_headers(850);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
rtl/hdsc_pkg.sv
rtl/hdsc_round_cell.sv
rtl/hdsc_compress.sv
rtl/header_double_sha256_check_unit.sv
verif/header_double_sha256_check_unit_tb.sv
